[rtl/core/nabb_pkg.sv]
// ----------------------------------------------------------------------------
// nabb_pkg
// Shared widths, register indexes and the line store entry type for the
// null-aware block binning unit.
// ----------------------------------------------------------------------------
package nabb_pkg;

	localparam int MAX_OUT_COLS = 1024;
	localparam int MAX_SHIFT    = 2;
	localparam int MAX_FACTOR   = 1 << MAX_SHIFT;

	localparam int PIX_W   = 32;                                  // Q16.16 pixel
	localparam int SUM_W   = 36;                                  // Q20.16 block sum
	localparam int OCOL_W  = $clog2(MAX_OUT_COLS);                // binned column
	localparam int COLS_W  = OCOL_W + 1;                          // output_columns
	localparam int COL_W   = $clog2(MAX_OUT_COLS * MAX_FACTOR);   // input column
	localparam int WIDTH_W = COL_W + 1;                           // input row width
	localparam int SHIFT_W = 2;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = COLS_W;

	localparam logic [CFG_IDX_W-1:0] REG_BIN_SHIFT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COLS = 1'd1;

	localparam logic [SHIFT_W-1:0] BIN_SHIFT_RST   = 2'd1;
	localparam logic [COLS_W-1:0]  OUTPUT_COLS_RST = COLS_W'(MAX_OUT_COLS);

	localparam int IN_TDATA_W  = ((PIX_W + 7) / 8) * 8;
	localparam int OUT_FIELD_W = SUM_W + OCOL_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

	typedef struct packed {
		logic                    valid;
		logic signed [SUM_W-1:0] sum;
	} line_entry_t;

endpackage

[rtl/core/null_aware_block_binning_unit.sv]
// ----------------------------------------------------------------------------
// null_aware_block_binning_unit
// Sums each factor-by-factor block of a raster pixel stream, skipping null
// pixels; column partial sums of a band live in a one-port-read line store.
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  s_axis    | in        | tdata: pixel_value[31:0]; tuser: pixel_null
//  m_axis    | out       | tdata: binned_sum[35:0], out_column[45:36], zero[47:46];
//            |           | tuser: binned_null; tlast: row_end
//  cfg       | in        | cfg_we, cfg_index (0 bin_shift, 1 output_columns), cfg_wdata
//
//  One pixel per clock unless a result waits in a full output register; the pixel
//  that closes a block goes to stage 1 (line store read), then add and output register.
//  Block ends of later band rows read the line store; block ends of all but the
//  last band row write back from stage 1 next cycle; a same-entry read takes it in flight.
//  Reset clears counters, the horizontal group sum and the pipeline valids;
//  the line store is not cleared and needs no clearing pass.
//  Input stalls only while a result waits in a full output register.
// ----------------------------------------------------------------------------
module null_aware_block_binning_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_we,
	input  logic [nabb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [nabb_pkg::CFG_W-1:0]           cfg_wdata,
	// pixel stream
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [nabb_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // pixel_value
	input  logic                                 s_axis_tuser,   // pixel_null
	// binned stream
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [nabb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // binned_sum, out_column
	output logic                                 m_axis_tuser,   // binned_null
	output logic                                 m_axis_tlast    // row_end
);
	import nabb_pkg::*;

	// configuration registers
	logic [SHIFT_W-1:0] bin_shift_q;
	logic [COLS_W-1:0]  out_cols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_shift_q <= BIN_SHIFT_RST;
			out_cols_q  <= OUTPUT_COLS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BIN_SHIFT:   bin_shift_q <= cfg_wdata[SHIFT_W-1:0];
				REG_OUTPUT_COLS: out_cols_q  <= cfg_wdata[COLS_W-1:0];
				default: ;
			endcase
		end
	end

	// effective configuration
	logic [SHIFT_W-1:0] shift;
	logic [COLS_W-1:0]  cols;
	logic [WIDTH_W-1:0] row_width;
	logic [1:0]         sub_mask;

	always_comb begin
		shift = (bin_shift_q > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT) : bin_shift_q;
		if (out_cols_q == '0)
			cols = COLS_W'(1);
		else if (out_cols_q > COLS_W'(MAX_OUT_COLS))
			cols = COLS_W'(MAX_OUT_COLS);
		else
			cols = out_cols_q;
		row_width = WIDTH_W'(cols) << shift;
		sub_mask  = 2'((3'd1 << shift) - 3'd1);
	end

	// position counters and horizontal group sum
	logic [COL_W-1:0]        col_q;
	logic [1:0]              band_q;
	logic signed [SUM_W-1:0] group_sum_q;
	logic                    group_valid_q;

	// pipeline stage 1 and output register
	logic                    valid_s1;
	logic                    emit_s1;
	logic                    use_mem_s1;
	logic signed [SUM_W-1:0] group_sum_s1;
	logic                    group_valid_s1;
	logic [OCOL_W-1:0]       ocol_s1;
	logic                    row_end_s1;
	logic                    adv_s1;

	logic                    out_valid_q;
	logic signed [SUM_W-1:0] out_sum_q;
	logic                    out_null_q;
	logic [OCOL_W-1:0]       out_col_q;
	logic                    out_last_q;

	logic accept;
	assign adv_s1        = valid_s1 && (!emit_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// decode of the accepted pixel
	logic [COL_W-1:0]        col_eff;
	logic [1:0]              band_eff;
	logic [OCOL_W-1:0]       ocol;
	logic                    block_end;
	logic                    last_band;
	logic                    row_end;
	logic [WIDTH_W-1:0]      col_next;
	logic                    row_wrap;
	logic signed [SUM_W-1:0] pix_ext;
	logic signed [SUM_W-1:0] group_sum_new;
	logic                    group_valid_new;

	always_comb begin
		col_eff   = (WIDTH_W'(col_q) >= row_width) ? '0 : col_q;
		band_eff  = band_q & sub_mask;
		ocol      = OCOL_W'(col_eff >> shift);
		block_end = ((col_eff[1:0] & sub_mask) == sub_mask);
		last_band = (band_eff == sub_mask);
		row_end   = (COLS_W'(ocol) == (cols - COLS_W'(1)));
		col_next  = WIDTH_W'(col_eff) + WIDTH_W'(1);
		row_wrap  = (col_next >= row_width);
		pix_ext   = SUM_W'(signed'(s_axis_tdata[PIX_W-1:0]));
		group_sum_new   = s_axis_tuser ? group_sum_q : group_sum_q + pix_ext;
		group_valid_new = group_valid_q || !s_axis_tuser;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q         <= '0;
			band_q        <= '0;
			group_sum_q   <= '0;
			group_valid_q <= 1'b0;
		end else if (accept) begin
			if (row_wrap) begin
				col_q  <= '0;
				band_q <= (band_eff + 2'd1) & sub_mask;
			end else begin
				col_q  <= col_next[COL_W-1:0];
				band_q <= band_eff;
			end
			// close the group on a block end, else keep summing
			if (block_end) begin
				group_sum_q   <= '0;
				group_valid_q <= 1'b0;
			end else begin
				group_sum_q   <= group_sum_new;
				group_valid_q <= group_valid_new;
			end
		end
	end

	// line store: read on block ends of later band rows, write back from s1
	line_entry_t       line_mem [MAX_OUT_COLS];
	line_entry_t       rd_q;
	line_entry_t       wr_data;
	logic              rd_en;
	logic              wr_en;
	logic [OCOL_W-1:0] rd_addr;

	assign rd_en   = accept && block_end && (band_eff != 2'd0);
	assign rd_addr = ocol;

	// stage 1 sum
	logic signed [SUM_W-1:0] acc;
	logic                    acc_valid;

	always_comb begin
		if (use_mem_s1) begin
			acc       = rd_q.sum + group_sum_s1;
			acc_valid = rd_q.valid || group_valid_s1;
		end else begin
			acc       = group_sum_s1;
			acc_valid = group_valid_s1;
		end
		wr_data.sum   = acc;
		wr_data.valid = acc_valid;
	end

	assign wr_en = valid_s1 && !emit_s1;

	always_ff @(posedge clk) begin
		if (wr_en)
			line_mem[ocol_s1] <= wr_data;
		// forward a write to the same entry in flight
		if (rd_en)
			rd_q <= (wr_en && (ocol_s1 == rd_addr)) ? wr_data : line_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= accept && block_end;
	end

	always_ff @(posedge clk) begin
		if (accept && block_end) begin
			emit_s1        <= last_band;
			use_mem_s1     <= (band_eff != 2'd0);
			group_sum_s1   <= group_sum_new;
			group_valid_s1 <= group_valid_new;
			ocol_s1        <= ocol;
			row_end_s1     <= row_end;
		end
	end

	// output register
	logic out_load;
	assign out_load = adv_s1 && emit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sum_q  <= acc_valid ? acc : '0;
			out_null_q <= !acc_valid;
			out_col_q  <= ocol_s1;
			out_last_q <= row_end_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_col_q, out_sum_q};
	assign m_axis_tuser  = out_null_q;
	assign m_axis_tlast  = out_last_q;

endmodule

[rtl/core/nabb_checker.sv]
// ----------------------------------------------------------------------------
// nabb_checker
// Port-level checks for the null-aware block binning unit.
// ----------------------------------------------------------------------------
module nabb_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 cfg_we,
	input logic [nabb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input logic [nabb_pkg::CFG_W-1:0]           cfg_wdata,
	input logic                                 s_axis_tvalid,
	input logic                                 s_axis_tready,
	input logic [nabb_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	input logic                                 s_axis_tuser,
	input logic                                 m_axis_tvalid,
	input logic                                 m_axis_tready,
	input logic [nabb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	input logic                                 m_axis_tuser,
	input logic                                 m_axis_tlast
);
	import nabb_pkg::*;

	// a null block carries a zero sum
	a_null_zero_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[SUM_W-1:0] == '0)
		else $error("null result with nonzero sum");

	// input backpressure only comes from a result waiting downstream
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty output");

	// a fresh result follows a pixel transfer, through stage 1 and the output register
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result without a closing pixel");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
		else $error("stalled result changed");

endmodule

bind null_aware_block_binning_unit nabb_checker u_nabb_checker (.*);
